// ----- hdl/tdl_pkg.sv -----
// Shared types, constants and helpers for the TD(lambda) trace update core.
package tdl_pkg;

	// default weight memory depth
	localparam int NUM_WEIGHTS_DEF = 4096;

	// field widths
	localparam int FUNC_W   = 2;
	localparam int FIDX_W   = 12;
	localparam int WORD_W   = 32;
	localparam int RATE_W   = 16;
	localparam int TRACE_W  = 16;
	localparam int CIDX_W   = 2;

	// item functions
	localparam logic [FUNC_W-1:0] FN_FEATURE = 2'd0;
	localparam logic [FUNC_W-1:0] FN_UPDATE  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR   = 2'd2;
	localparam logic [FUNC_W-1:0] FN_READ    = 2'd3;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_STEP_SIZE   = 2'd0;
	localparam logic [CIDX_W-1:0] REG_DISCOUNT    = 2'd1;
	localparam logic [CIDX_W-1:0] REG_DISC_LAMBDA = 2'd2;
	localparam logic [CIDX_W-1:0] REG_TRACE_MODE  = 2'd3;

	// configuration reset values
	localparam logic [RATE_W-1:0] STEP_SIZE_RST   = 16'd655;
	localparam logic [RATE_W-1:0] DISCOUNT_RST    = 16'd64880;
	localparam logic [RATE_W-1:0] DISC_LAMBDA_RST = 16'd58392;

	// trace of one in Q4.12
	localparam logic [TRACE_W-1:0] TRACE_ONE = 16'h1000;

	// memory pipeline operations
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_FEAT  = 3'd0;
	localparam logic [OP_W-1:0] OP_READ  = 3'd1;
	localparam logic [OP_W-1:0] OP_UPD   = 3'd2;
	localparam logic [OP_W-1:0] OP_CLRT  = 3'd3;
	localparam logic [OP_W-1:0] OP_INIT  = 3'd4;

	// commands from controller to datapath
	typedef struct packed {
		logic            load_in;
		logic            calc_gq;
		logic            calc_td;
		logic            calc_m;
		logic            load_res;
		logic            clr_acc;
		logic            pipe_valid;
		logic            pipe_item;
		logic [OP_W-1:0] pipe_op;
	} tdl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              in_range;
		logic              pipe_busy;
	} tdl_stat_t;

	// saturate a 38-bit signed value to 32 bits
	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [37:0] v);
		logic signed [WORD_W-1:0] r;
		if (v[37:31] == {7{v[37]}}) begin
			r = v[31:0];
		end else if (v[37]) begin
			r = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(WORD_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// ----- hdl/tdl_ctrl.sv -----
// Controller state machine: item sequencing, memory sweeps and result handoff.
module tdl_ctrl import tdl_pkg::*; #(
	parameter int NUM_WEIGHTS = NUM_WEIGHTS_DEF,
	parameter int IDX_W       = $clog2(NUM_WEIGHTS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [FUNC_W-1:0] in_func,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  tdl_stat_t         stat,
	output tdl_cmd_t          cmd,
	output logic [IDX_W-1:0]  sweep_addr
);

	localparam logic [3:0] ST_INIT       = 4'd0;
	localparam logic [3:0] ST_INIT_DRAIN = 4'd1;
	localparam logic [3:0] ST_IDLE       = 4'd2;
	localparam logic [3:0] ST_ISSUE      = 4'd3;
	localparam logic [3:0] ST_GQ         = 4'd4;
	localparam logic [3:0] ST_TD         = 4'd5;
	localparam logic [3:0] ST_M          = 4'd6;
	localparam logic [3:0] ST_SWEEP      = 4'd7;
	localparam logic [3:0] ST_DRAIN      = 4'd8;
	localparam logic [3:0] ST_FINISH     = 4'd9;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WEIGHTS - 1);

	logic [3:0]       state_q, state_d;
	logic [IDX_W-1:0] cnt_q;
	logic             cnt_inc;
	logic             cnt_last;
	logic             out_valid_q;

	assign cnt_last   = (cnt_q == LAST_IDX);
	assign sweep_addr = cnt_q;
	assign out_valid  = out_valid_q;
	assign in_ready   = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cnt_inc = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.pipe_valid = 1'b1;
				cmd.pipe_op    = OP_INIT;
				cnt_inc        = 1'b1;
				if (cnt_last) state_d = ST_INIT_DRAIN;
			end
			ST_INIT_DRAIN: begin
				if (!stat.pipe_busy) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) begin
					case (in_func)
						FN_UPDATE: state_d = ST_GQ;
						FN_CLEAR:  state_d = ST_SWEEP;
						default:   state_d = ST_ISSUE;
					endcase
				end
			end
			ST_ISSUE: begin
				cmd.pipe_valid = stat.in_range;
				cmd.pipe_item  = 1'b1;
				cmd.pipe_op    = (stat.func == FN_FEATURE) ? OP_FEAT : OP_READ;
				state_d        = ST_DRAIN;
			end
			ST_GQ: begin
				cmd.calc_gq = 1'b1;
				state_d     = ST_TD;
			end
			ST_TD: begin
				cmd.calc_td = 1'b1;
				state_d     = ST_M;
			end
			ST_M: begin
				cmd.calc_m = 1'b1;
				state_d    = ST_SWEEP;
			end
			ST_SWEEP: begin
				cmd.pipe_valid = 1'b1;
				cmd.pipe_op    = (stat.func == FN_UPDATE) ? OP_UPD : OP_CLRT;
				cnt_inc        = 1'b1;
				if (cnt_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_res = 1'b1;
					cmd.clr_acc  = (stat.func == FN_UPDATE);
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state, sweep counter, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) cnt_q <= cnt_last ? '0 : cnt_q + IDX_W'(1);
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/tdl_datapath.sv -----
// Datapath: configuration registers, weight and trace memories, TD arithmetic.
module tdl_datapath import tdl_pkg::*; #(
	parameter int NUM_WEIGHTS = NUM_WEIGHTS_DEF,
	parameter int IDX_W       = $clog2(NUM_WEIGHTS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration writes
	input  logic                     cfg_we,
	input  logic [CIDX_W-1:0]        cfg_index,
	input  logic [RATE_W-1:0]        cfg_data,
	// input item fields
	input  logic [FUNC_W-1:0]        in_func,
	input  logic [FIDX_W-1:0]        in_index,
	input  logic signed [WORD_W-1:0] in_reward,
	input  logic signed [WORD_W-1:0] in_next_value,
	// control
	input  tdl_cmd_t                 cmd,
	input  logic [IDX_W-1:0]         sweep_addr,
	output tdl_stat_t                stat,
	// result fields
	output logic signed [WORD_W-1:0] value_estimate,
	output logic signed [WORD_W-1:0] td_error,
	output logic signed [WORD_W-1:0] weight_out
);

	// configuration
	logic [RATE_W-1:0] step_q, disc_q, dlam_q;
	logic              mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_SIZE_RST;
			disc_q <= DISCOUNT_RST;
			dlam_q <= DISC_LAMBDA_RST;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_SIZE:   step_q <= cfg_data;
				REG_DISCOUNT:    disc_q <= cfg_data;
				REG_DISC_LAMBDA: dlam_q <= cfg_data;
				REG_TRACE_MODE:  mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// captured item
	logic [FUNC_W-1:0]        func_q;
	logic [FIDX_W-1:0]        idx_q;
	logic signed [WORD_W-1:0] reward_q, next_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q   <= in_func;
			idx_q    <= in_index;
			reward_q <= in_reward;
			next_q   <= in_next_value;
		end
	end

	logic             in_range;
	logic [IDX_W-1:0] item_addr;
	assign in_range  = (32'(idx_q) < 32'(NUM_WEIGHTS));
	assign item_addr = IDX_W'(32'(idx_q));

	// TD error and step factor, one multiply per cycle
	logic signed [48:0]       gq_q, mprod_q;
	logic signed [WORD_W-1:0] td_q, acc_q;
	logic signed [33:0]       td_sum;
	logic signed [WORD_W-1:0] m_fac;

	assign td_sum = 34'(reward_q) + 34'($signed(gq_q[47:16])) - 34'(acc_q);
	assign m_fac  = mprod_q[47:16];

	always_ff @(posedge clk) begin
		if (cmd.calc_gq) gq_q    <= 49'($signed({1'b0, disc_q})) * 49'(next_q);
		if (cmd.calc_td) td_q    <= sat32(38'(td_sum));
		if (cmd.calc_m)  mprod_q <= 49'($signed({1'b0, step_q})) * 49'(td_q);
	end

	// memories
	logic [WORD_W-1:0]  wmem [NUM_WEIGHTS];
	logic [TRACE_W-1:0] tmem [NUM_WEIGHTS];
	logic [IDX_W-1:0]   rd_addr;

	assign rd_addr = cmd.pipe_item ? item_addr : sweep_addr;

	// stage 1: registered read data
	logic                     pv_s1;
	logic [OP_W-1:0]          op_s1;
	logic [IDX_W-1:0]         addr_s1;
	logic signed [WORD_W-1:0] w_s1;
	logic [TRACE_W-1:0]       t_s1;

	// stage 2: products and write data
	logic                     pv_s2;
	logic [OP_W-1:0]          op_s2;
	logic [IDX_W-1:0]         addr_s2;
	logic signed [WORD_W-1:0] w_s2;
	logic signed [48:0]       prod_s2;
	logic [TRACE_W-1:0]       twr_s2;

	always_ff @(posedge clk) begin
		w_s1 <= wmem[rd_addr];
		t_s1 <= tmem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			pv_s2 <= 1'b0;
		end else begin
			pv_s1 <= cmd.pipe_valid;
			pv_s2 <= pv_s1;
		end
	end

	// trace values for a feature hit and for an update decay
	logic [16:0]        t_inc;
	logic [TRACE_W-1:0] t_feat;
	logic [31:0]        t_decay;
	assign t_inc   = {1'b0, t_s1} + {1'b0, TRACE_ONE};
	assign t_feat  = mode_q ? TRACE_ONE : (t_inc[16] ? {TRACE_W{1'b1}} : t_inc[15:0]);
	assign t_decay = 32'(t_s1) * 32'(dlam_q);

	always_ff @(posedge clk) begin
		op_s1   <= cmd.pipe_op;
		addr_s1 <= rd_addr;
		op_s2   <= op_s1;
		addr_s2 <= addr_s1;
		w_s2    <= w_s1;
		prod_s2 <= 49'(m_fac) * 49'($signed({1'b0, t_s1}));
		case (op_s1)
			OP_FEAT: twr_s2 <= t_feat;
			OP_UPD:  twr_s2 <= t_decay[31:16];
			default: twr_s2 <= '0;
		endcase
	end

	// stage 2 write back
	logic signed [37:0]       w_sum;
	logic signed [WORD_W-1:0] w_new;
	logic                     w_we, t_we;
	assign w_sum = 38'(w_s2) + 38'($signed(prod_s2[48:12]));
	assign w_new = (op_s2 == OP_UPD) ? sat32(w_sum) : '0;
	assign w_we  = pv_s2 && (op_s2 == OP_UPD || op_s2 == OP_INIT);
	assign t_we  = pv_s2 && (op_s2 == OP_UPD || op_s2 == OP_INIT ||
	                         op_s2 == OP_FEAT || op_s2 == OP_CLRT);

	always_ff @(posedge clk) begin
		if (w_we) wmem[addr_s2] <= w_new;
		if (t_we) tmem[addr_s2] <= twr_s2;
	end

	// value accumulator and read capture
	logic signed [WORD_W-1:0] wout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.clr_acc) begin
			acc_q <= '0;
		end else if (pv_s1 && op_s1 == OP_FEAT) begin
			acc_q <= sat32(38'(acc_q) + 38'(w_s1));
		end
	end

	always_ff @(posedge clk) begin
		if (pv_s1 && op_s1 == OP_READ) wout_q <= w_s1;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			value_estimate <= acc_q;
			td_error       <= (func_q == FN_UPDATE) ? td_q : '0;
			weight_out     <= (func_q == FN_READ && in_range) ? wout_q : '0;
		end
	end

	assign stat.func      = func_q;
	assign stat.in_range  = in_range;
	assign stat.pipe_busy = pv_s1 | pv_s2;

endmodule

// ----- hdl/td_lambda_trace_update_core.sv -----
// Top level of the linear TD(lambda) eligibility trace update core.
//
// Linear TD(lambda) learner over a NUM_WEIGHTS-entry weight and trace memory
// (Q16.16 weights, Q4.12 traces, Q0.16 rates). Every input beat yields one
// output beat. A feature or read beat goes through issue, registered memory
// read, compute, write back, then the result register; an out-of-range index
// skips the memory pipeline. An update beat first computes gamma*q_next, td
// and alpha*td in turn in their own registers, then moves one entry per cycle
// through the memory pipeline, set by the single read port of each memory,
// and then drains the pipeline. A clear-traces beat sweeps the same way
// without the arithmetic steps. After reset a clearing pass writes every
// entry and s_tready stays low until the pass has drained; configuration
// writes are always taken. A result waiting on m_tready does not block
// acceptance of the next beat.
module td_lambda_trace_update_core import tdl_pkg::*; #(
	parameter int NUM_WEIGHTS = NUM_WEIGHTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [79:0]       s_tdata,  // feature_index[11:0], reward[43:12], next_value[75:44]
	input  logic [FUNC_W-1:0] s_tuser,  // func[1:0]
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [95:0]       m_tdata,  // value_estimate[31:0], td_error[63:32], weight_out[95:64]
	// configuration writes
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [RATE_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(NUM_WEIGHTS);

	tdl_cmd_t          cmd;
	tdl_stat_t         stat;
	logic [IDX_W-1:0]  sweep_addr;
	logic signed [WORD_W-1:0] value_estimate, td_error, weight_out;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {weight_out, td_error, value_estimate};

	tdl_ctrl #(
		.NUM_WEIGHTS (NUM_WEIGHTS),
		.IDX_W       (IDX_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_func    (s_tuser),
		.in_ready   (s_tready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.stat       (stat),
		.cmd        (cmd),
		.sweep_addr (sweep_addr)
	);

	tdl_datapath #(
		.NUM_WEIGHTS (NUM_WEIGHTS),
		.IDX_W       (IDX_W)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid & cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_func        (s_tuser),
		.in_index       (s_tdata[11:0]),
		.in_reward      (s_tdata[43:12]),
		.in_next_value  (s_tdata[75:44]),
		.cmd            (cmd),
		.sweep_addr     (sweep_addr),
		.stat           (stat),
		.value_estimate (value_estimate),
		.td_error       (td_error),
		.weight_out     (weight_out)
	);

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the TD(lambda) trace update core: stream stimulus, prediction, compare.
`timescale 1ns / 100ps

module tb_top;
	import tdl_pkg::*;

	localparam int NUM_W = NUM_WEIGHTS_DEF;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic [FIDX_W-1:0]        feat_idx;
		logic signed [WORD_W-1:0] reward;
		logic signed [WORD_W-1:0] next_value;
	} item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value_estimate;
		logic signed [WORD_W-1:0] td_error;
		logic signed [WORD_W-1:0] weight_out;
	} result_t;

	// block ports
	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [79:0]       s_tdata   = '0;  // feature_index[11:0], reward[43:12], next_value[75:44]
	logic [FUNC_W-1:0] s_tuser   = '0;  // func[1:0]
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [95:0]       m_tdata;         // value_estimate[31:0], td_error[63:32], weight_out[95:64]
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [RATE_W-1:0] cfg_data  = '0;

	// learner state as the bench sees it
	logic signed [WORD_W-1:0] w_mem [NUM_W];
	logic [TRACE_W-1:0]       t_mem [NUM_W];
	logic signed [WORD_W-1:0] est_acc      = '0;
	logic [RATE_W-1:0]        alpha        = STEP_SIZE_RST;
	logic [RATE_W-1:0]        gamma        = DISCOUNT_RST;
	logic [RATE_W-1:0]        gamma_lambda = DISC_LAMBDA_RST;
	logic                     replace_mode = 1'b0;

	item_t   pending_items[$];
	result_t expected_results[$];
	item_t   cur_item;
	int      n_pushed   = 0;
	int      n_accepted = 0;
	int      n_checked  = 0;
	int      n_err      = 0;

	// sender burst / gap state
	int burst_left = 8;
	int gap_left   = 0;

	// receiver stall pattern and long hold-off
	logic [15:0] ready_pat = 16'hFFFF;
	logic [3:0]  pat_pos   = '0;
	int          hold_cnt  = 0;
	int          hold_at   = 300;

	// hot feature indexes for the current phase
	logic [FIDX_W-1:0] pool [8];

	td_lambda_trace_update_core #(.NUM_WEIGHTS(NUM_W)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [WORD_W-1:0] sat_word(input longint v);
		logic signed [WORD_W-1:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// one learner step: updates the bench copy of the state, returns the result beat
	function automatic result_t learner_step(input item_t it);
		result_t     r;
		longint      gq;
		longint      m;
		longint      d;
		logic [31:0] t;
		logic [31:0] p;
		r.value_estimate = est_acc;
		r.td_error       = '0;
		r.weight_out     = '0;
		case (it.func)
			FN_FEATURE: begin
				if (it.feat_idx < NUM_W) begin
					est_acc = sat_word(longint'(est_acc) + longint'(w_mem[it.feat_idx]));
					if (replace_mode) begin
						t_mem[it.feat_idx] = TRACE_ONE;
					end else begin
						t = 32'(t_mem[it.feat_idx]) + 32'(TRACE_ONE);
						t_mem[it.feat_idx] = (t > 32'hFFFF) ? 16'hFFFF : t[15:0];
					end
				end
				r.value_estimate = est_acc;
			end
			FN_UPDATE: begin
				gq = (longint'(gamma) * longint'(it.next_value)) >>> 16;
				r.td_error = sat_word(longint'(it.reward) + gq - longint'(est_acc));
				m = (longint'(alpha) * longint'(r.td_error)) >>> 16;
				for (int i = 0; i < NUM_W; i++) begin
					d = (m * longint'(t_mem[i])) >>> 12;
					w_mem[i] = sat_word(longint'(w_mem[i]) + d);
					p = 32'(t_mem[i]) * 32'(gamma_lambda);
					t_mem[i] = p[31:16];
				end
				est_acc = '0;
			end
			FN_CLEAR: begin
				for (int i = 0; i < NUM_W; i++) t_mem[i] = '0;
			end
			default: begin
				if (it.feat_idx < NUM_W) r.weight_out = w_mem[it.feat_idx];
			end
		endcase
		return r;
	endfunction

	// mix of full-range, small and boundary Q16.16 words
	function automatic logic [31:0] rand_word();
		logic [31:0] w;
		case ($urandom_range(0, 4))
			0, 1: w = $urandom;
			2: w = $urandom_range(0, 524288) - 262144;
			3: begin
				case ($urandom_range(0, 3))
					0: w = 32'h7FFF_FFFF;
					1: w = 32'h8000_0000;
					2: w = 32'h0000_0000;
					default: w = 32'h0001_0000;
				endcase
			end
			default: w = $urandom_range(0, 32'h0004_0000);
		endcase
		return w;
	endfunction

	function automatic logic [RATE_W-1:0] rand_rate();
		logic [RATE_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = '0;
			1: v = '1;
			default: v = RATE_W'($urandom_range(0, 65535));
		endcase
		return v;
	endfunction

	function automatic logic [FIDX_W-1:0] pick_idx();
		logic [FIDX_W-1:0] x;
		if ($urandom_range(0, 3) == 0) x = FIDX_W'($urandom_range(0, 4095));
		else x = pool[3'($urandom_range(0, 7))];
		return x;
	endfunction

	task automatic push_item(input logic [FUNC_W-1:0] func, input logic [FIDX_W-1:0] idx,
		input logic [31:0] rew, input logic [31:0] nv);
		item_t it;
		it.func       = func;
		it.feat_idx   = idx;
		it.reward     = rew;
		it.next_value = nv;
		pending_items.push_back(it);
		n_pushed++;
	endtask

	task automatic push_rand(input logic [FUNC_W-1:0] func, input logic [FIDX_W-1:0] idx);
		push_item(func, idx, rand_word(), rand_word());
	endtask

	// config beat, only issued while the core is idle
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [RATE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_STEP_SIZE:   alpha        = val;
			REG_DISCOUNT:    gamma        = val;
			REG_DISC_LAMBDA: gamma_lambda = val;
			REG_TRACE_MODE:  replace_mode = val[0];
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [RATE_W-1:0] a, input logic [RATE_W-1:0] g,
		input logic [RATE_W-1:0] gl, input logic mode);
		write_reg(REG_STEP_SIZE, a);
		write_reg(REG_DISCOUNT, g);
		write_reg(REG_DISC_LAMBDA, gl);
		write_reg(REG_TRACE_MODE, {{(RATE_W-1){1'b0}}, mode});
	endtask

	// all results in, plus a short settle
	task automatic wait_idle();
		while (n_checked != n_pushed) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// episodes of features then an update and a few reads; some noise and broken runs
	task automatic gen_random(input int n);
		int start;
		int k;
		int sel;
		start = n_pushed;
		while (n_pushed - start < n) begin
			sel = $urandom_range(0, 99);
			if (sel < 80) begin
				k = $urandom_range(1, 12);
				for (int j = 0; j < k; j++) begin
					push_rand(FN_FEATURE, pick_idx());
					if ($urandom_range(0, 39) == 0)
						push_rand(FN_CLEAR, FIDX_W'($urandom_range(0, 4095)));
				end
				if ($urandom_range(0, 9) != 0)
					push_rand(FN_UPDATE, FIDX_W'($urandom_range(0, 4095)));
				k = $urandom_range(0, 3);
				for (int j = 0; j < k; j++) push_rand(FN_READ, pick_idx());
			end else if (sel < 97) begin
				push_rand(FUNC_W'($urandom_range(0, 3)), FIDX_W'($urandom_range(0, 4095)));
			end else begin
				push_rand(FN_CLEAR, FIDX_W'($urandom_range(0, 4095)));
			end
		end
	endtask

	// stimulus and phase control
	initial begin
		for (int i = 0; i < NUM_W; i++) begin
			w_mem[i] = '0;
			t_mem[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: index extremes, trace saturation, clear keeps estimate, extreme update
		push_rand(FN_READ, 12'd0);
		push_rand(FN_FEATURE, 12'd0);
		push_rand(FN_FEATURE, 12'd4095);
		for (int i = 0; i < 16; i++) push_rand(FN_FEATURE, 12'd5);
		push_rand(FN_CLEAR, 12'd0);
		push_rand(FN_FEATURE, 12'd5);
		push_item(FN_UPDATE, 12'd4095, 32'h7FFF_FFFF, 32'h8000_0000);
		push_rand(FN_READ, 12'd5);
		push_item(FN_UPDATE, 12'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		push_rand(FN_READ, 12'd4095);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			case (ph)
				0: set_all('1, '1, '1, 1'b0);
				1: set_all('0, '0, '0, 1'b1);
				default: set_all(rand_rate(), rand_rate(), rand_rate(), 1'($urandom_range(0, 1)));
			endcase
			for (int j = 0; j < 8; j++) begin
				if ($urandom_range(0, 4) == 0) pool[j] = j[0] ? 12'd4095 : 12'd0;
				else pool[j] = FIDX_W'($urandom_range(0, 4095));
			end
			gen_random(180);
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (n_err == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// input driver: bursts with random gaps, prediction on every accepted beat
	always @(posedge clk) begin : drv
		item_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(learner_step(cur_item));
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					nxt = pending_items.pop_front();
					cur_item = nxt;
					s_tdata  <= {4'b0, nxt.next_value, nxt.reward, nxt.feat_idx};
					s_tuser  <= nxt.func;
					s_tvalid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the core backs up into its input
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (n_accepted >= hold_at) begin
			hold_cnt <= 1500;
			hold_at  <= hold_at + 500;
		end
	end

	// output monitor: compare every result beat with the oldest prediction
	always @(posedge clk) begin : mon
		result_t got;
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.value_estimate = m_tdata[31:0];
				got.td_error       = m_tdata[63:32];
				got.weight_out     = m_tdata[95:64];
				if (expected_results.size() == 0) begin
					n_err++;
					if (n_err <= 10) $display("unexpected result beat: %h", m_tdata);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						n_err++;
						if (n_err <= 10)
							$display("mismatch at result %0d: est exp %h got %h, td exp %h got %h, w exp %h got %h",
								n_checked, want.value_estimate, got.value_estimate,
								want.td_error, got.td_error, want.weight_out, got.weight_out);
					end
				end
				n_checked++;
			end
			// new stall pattern each time the pattern position wraps: open, random, mostly open or sparse
			if (pat_pos == 4'd15) begin
				case ($urandom_range(0, 3))
					0: ready_pat <= 16'hFFFF;
					1: ready_pat <= 16'($urandom);
					2: ready_pat <= 16'($urandom | $urandom);
					default: ready_pat <= 16'($urandom & $urandom);
				endcase
			end
			pat_pos  <= pat_pos + 4'd1;
			m_tready <= ready_pat[pat_pos] && (hold_cnt == 0);
		end
	end

	// run limit
	initial begin
		#(30_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
